// File: rtl/gf2_131_onb_field_alu_macros.svh
// Assertion macros used by the checker file of the field ALU.
`ifndef GF2_131_ONB_FIELD_ALU_MACROS_SVH
`define GF2_131_ONB_FIELD_ALU_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define GF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define GF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gfonb_pkg.sv
// ----------------------------------------------------------------------------
// gfonb_pkg
// Types, constants, bit-permutation functions and the inversion step table of the GF(2^131) ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package gfonb_pkg;

    localparam int unsigned FieldDeg = 131;
    localparam int unsigned SymLen   = 2 * FieldDeg + 1;
    localparam int unsigned CntW     = 8;

    typedef logic [FieldDeg-1:0] t_elem;
    typedef logic [SymLen-1:0]   t_sym;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_MUL  = 3'd1,
        OP_SQR  = 3'd2,
        OP_FROB = 3'd3,
        OP_INV  = 3'd4,
        OP_HTR  = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_HT,
        ST_OUT
    } t_state;

    // Squaring: coefficient of beta_i moves to beta_fold(2i).
    function automatic t_elem fe_sqr(input t_elem x);
        t_elem r;
        int unsigned m;
        int unsigned f;
        r = '0;
        for (int unsigned i = 1; i <= FieldDeg; i++) begin
            m = 2 * i;
            f = (m <= FieldDeg) ? m : SymLen - m;
            r[f-1] = x[i-1];
        end
        return r;
    endfunction

    // Symmetric expansion: entries k and 263-k hold coefficient k, entry 0 is zero.
    function automatic t_sym fe_sym(input t_elem x);
        t_sym s;
        int unsigned f;
        s = '0;
        for (int unsigned k = 1; k < SymLen; k++) begin
            f = (k <= FieldDeg) ? k : SymLen - k;
            s[k] = x[f-1];
        end
        return s;
    endfunction

    // Squaring count of each Itoh-Tsujii step along the addition chain.
    function automatic logic [CntW-1:0] inv_step(input logic [2:0] idx);
        logic [CntW-1:0] v;
        case (idx)
            3'd0:    v = 8'd1;
            3'd1:    v = 8'd2;
            3'd2:    v = 8'd4;
            3'd3:    v = 8'd8;
            3'd4:    v = 8'd16;
            3'd5:    v = 8'd32;
            3'd6:    v = 8'd1;
            default: v = 8'd65;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/gf2_131_onb_field_alu.sv
// ----------------------------------------------------------------------------
// gf2_131_onb_field_alu
// GF(2^131) type II optimal normal basis ALU with a shared serial multiplier.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_valid, o_stall) takes one item: opcode, operands
// a and b and a Frobenius exponent. The output channel (o_valid, i_stall)
// returns one result item per input item with the element, ok and the trace
// of a. One item is worked on at a time; o_stall stays high from acceptance
// until the result has been taken.
// Add, square, inverse of zero and unused codes go straight to the result
// item; the Frobenius exponent j is reduced mod 131 first. The inverse runs
// eight chain steps, each of squarings and one multiply, then one final
// squaring. The input reopens in the cycle after the result is taken. The
// serial multiplier takes one coefficient of b per cycle.
// Reset clears the sequencer and drops o_valid. While i_stall is high the
// result item holds steady and no new item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module gf2_131_onb_field_alu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [63:0] i_a_word0,
    input  wire logic [63:0] i_a_word1,
    input  wire logic [2:0]  i_a_word2,
    input  wire logic [63:0] i_b_word0,
    input  wire logic [63:0] i_b_word1,
    input  wire logic [2:0]  i_b_word2,
    input  wire logic [7:0]  i_frob_power,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_r_word0,
    output logic [63:0]      o_r_word1,
    output logic [2:0]       o_r_word2,
    output logic             o_ok,
    output logic             o_trace_bit
);

    localparam logic [2:0] LastStep = 3'd7;
    localparam logic [2:0] MixStep  = 3'd6;

    gfonb_pkg::t_state          r_state, n_state;
    logic [2:0]                 r_op, n_op;
    logic [2:0]                 r_step, n_step;
    logic [gfonb_pkg::CntW-1:0] r_cnt, n_cnt;
    gfonb_pkg::t_elem           r_a, n_a;
    gfonb_pkg::t_elem           r_x, n_x;
    gfonb_pkg::t_elem           r_acc, n_acc;
    gfonb_pkg::t_elem           r_b, n_b;
    gfonb_pkg::t_elem           r_res, n_res;
    logic                       r_ok, n_ok;
    logic                       r_trace, n_trace;

    gfonb_pkg::t_elem           w_in_a, w_in_b, w_x4, w_prod;
    logic                       w_mul_start;
    logic                       w_mul_done;
    logic [7:0]                 w_jmod;
    logic                       w_acc;

    assign w_in_a = {i_a_word2, i_a_word1, i_a_word0};
    assign w_in_b = {i_b_word2, i_b_word1, i_b_word0};
    assign w_x4   = gfonb_pkg::fe_sqr(gfonb_pkg::fe_sqr(r_x));
    assign w_jmod = (i_frob_power >= 8'd131) ? (i_frob_power - 8'd131) : i_frob_power;
    assign w_acc  = i_valid && !o_stall;

    gfonb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_x),
        .i_b     (r_b),
        .o_done  (w_mul_done),
        .o_p     (w_prod)
    );

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gfonb_pkg::ST_IDLE;
            r_op    <= '0;
            r_step  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_x     <= n_x;
        r_acc   <= n_acc;
        r_b     <= n_b;
        r_res   <= n_res;
        r_ok    <= n_ok;
        r_trace <= n_trace;
    end

    // Sequencer: next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_a         = r_a;
        n_x         = r_x;
        n_acc       = r_acc;
        n_b         = r_b;
        n_res       = r_res;
        n_ok        = r_ok;
        n_trace     = r_trace;
        w_mul_start = 1'b0;
        case (r_state)
            gfonb_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_op    = i_opcode;
                    n_a     = w_in_a;
                    n_x     = w_in_a;
                    n_acc   = w_in_a;
                    n_trace = ^w_in_a;
                    n_ok    = 1'b1;
                    n_res   = '0;
                    n_state = gfonb_pkg::ST_OUT;
                    case (i_opcode)
                        gfonb_pkg::OP_ADD: n_res = w_in_a ^ w_in_b;
                        gfonb_pkg::OP_MUL: begin
                            n_b     = w_in_b;
                            n_state = gfonb_pkg::ST_MUL_GO;
                        end
                        gfonb_pkg::OP_SQR: n_res = gfonb_pkg::fe_sqr(w_in_a);
                        gfonb_pkg::OP_FROB: begin
                            if (w_jmod == 8'd0) begin
                                n_res = w_in_a;
                            end else begin
                                n_cnt   = w_jmod;
                                n_state = gfonb_pkg::ST_SQR;
                            end
                        end
                        gfonb_pkg::OP_INV: begin
                            if (w_in_a == '0) begin
                                n_ok = 1'b0;
                            end else begin
                                n_step  = '0;
                                n_cnt   = gfonb_pkg::inv_step(3'd0);
                                n_state = gfonb_pkg::ST_SQR;
                            end
                        end
                        gfonb_pkg::OP_HTR: begin
                            n_cnt   = 8'd65;
                            n_state = gfonb_pkg::ST_HT;
                        end
                        default: n_res = '0;
                    endcase
                end
            end
            gfonb_pkg::ST_SQR: begin
                n_x   = gfonb_pkg::fe_sqr(r_x);
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == 8'd1) begin
                    if (r_op == gfonb_pkg::OP_FROB) begin
                        n_res   = gfonb_pkg::fe_sqr(r_x);
                        n_state = gfonb_pkg::ST_OUT;
                    end else begin
                        // The chain step before last multiplies by a itself.
                        n_b     = (r_step == MixStep) ? r_a : r_acc;
                        n_state = gfonb_pkg::ST_MUL_GO;
                    end
                end
            end
            gfonb_pkg::ST_MUL_GO: begin
                w_mul_start = 1'b1;
                n_state     = gfonb_pkg::ST_MUL_WAIT;
            end
            gfonb_pkg::ST_MUL_WAIT: begin
                if (w_mul_done) begin
                    if (r_op == gfonb_pkg::OP_MUL) begin
                        n_res   = w_prod;
                        n_state = gfonb_pkg::ST_OUT;
                    end else if (r_step == LastStep) begin
                        n_res   = gfonb_pkg::fe_sqr(w_prod);
                        n_state = gfonb_pkg::ST_OUT;
                    end else begin
                        n_x     = w_prod;
                        n_acc   = w_prod;
                        n_step  = r_step + 1'b1;
                        n_cnt   = gfonb_pkg::inv_step(r_step + 1'b1);
                        n_state = gfonb_pkg::ST_SQR;
                    end
                end
            end
            gfonb_pkg::ST_HT: begin
                // Half-trace sums a^(4^i); each cycle takes the next fourth power.
                n_x   = w_x4;
                n_acc = r_acc ^ w_x4;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == 8'd1) begin
                    n_res   = r_acc ^ w_x4;
                    n_state = gfonb_pkg::ST_OUT;
                end
            end
            gfonb_pkg::ST_OUT: begin
                if (!i_stall) begin
                    n_state = gfonb_pkg::ST_IDLE;
                end
            end
            default: n_state = gfonb_pkg::ST_IDLE;
        endcase
    end

    assign o_stall     = (r_state != gfonb_pkg::ST_IDLE);
    assign o_valid     = (r_state == gfonb_pkg::ST_OUT);
    assign o_r_word0   = r_res[63:0];
    assign o_r_word1   = r_res[127:64];
    assign o_r_word2   = r_res[130:128];
    assign o_ok        = r_ok;
    assign o_trace_bit = r_trace;

endmodule
`default_nettype wire

// File: rtl/gfonb_mul.sv
// ----------------------------------------------------------------------------
// gfonb_mul
// Bit-serial normal-basis multiplier: one coefficient of b per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gfonb_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire gfonb_pkg::t_elem   i_a,
    input  wire gfonb_pkg::t_elem   i_b,
    output logic                    o_done,
    output gfonb_pkg::t_elem        o_p
);

    localparam int unsigned Last = gfonb_pkg::FieldDeg - 1;

    gfonb_pkg::t_sym           r_u;
    gfonb_pkg::t_sym           r_v;
    gfonb_pkg::t_sym           w_s;
    gfonb_pkg::t_elem          r_b;
    gfonb_pkg::t_elem          r_p;
    logic [gfonb_pkg::CntW-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic                      w_last;

    assign w_s    = gfonb_pkg::fe_sym(i_a);
    assign w_last = (r_cnt == gfonb_pkg::CntW'(Last));

    // U holds the expansion rotated by +j, V by -j; term j adds U^V when b_j is set.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_u <= {w_s[0], w_s[gfonb_pkg::SymLen-1:1]};
            r_v <= {w_s[gfonb_pkg::SymLen-2:0], w_s[gfonb_pkg::SymLen-1]};
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_p <= r_p ^ (r_u[gfonb_pkg::FieldDeg:1] ^ r_v[gfonb_pkg::FieldDeg:1]);
            end
            r_u <= {r_u[0], r_u[gfonb_pkg::SymLen-1:1]};
            r_v <= {r_v[gfonb_pkg::SymLen-2:0], r_v[gfonb_pkg::SymLen-1]};
            r_b <= r_b >> 1;
        end
    end

    // Control: counts the coefficients of b.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule
`default_nettype wire

// File: rtl/gfonb_checker.sv
// ----------------------------------------------------------------------------
// gfonb_checker
// Port-level checks of the field ALU, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gf2_131_onb_field_alu_macros.svh"
module gfonb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [63:0] o_r_word0,
    input wire logic [63:0] o_r_word1,
    input wire logic [2:0]  o_r_word2,
    input wire logic        o_ok
);

    logic w_r_zero;

    assign w_r_zero = (o_r_word0 == 64'd0) && (o_r_word1 == 64'd0) && (o_r_word2 == 3'd0);

    // A pending result keeps the input side closed.
    `GF_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_valid, o_stall, "result shown while accepting")
    // A stalled result stays offered.
    `GF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped")
    // A failed inverse returns zero.
    `GF_ASSERT_IMP(a_ok_zero, i_clk, i_rst_n, o_valid && !o_ok, w_r_zero, "nonzero fail")
    // An accepted item closes the input side on the next cycle.
    `GF_ASSERT_NEXT(a_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "input not closed")

endmodule

bind gf2_131_onb_field_alu gfonb_checker u_gfonb_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_r_word0 (o_r_word0),
    .o_r_word1 (o_r_word1),
    .o_r_word2 (o_r_word2),
    .o_ok      (o_ok)
);
`default_nettype wire

// File: verif/gf2_131_onb_field_alu_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_131_onb_field_alu_test
// Self-checking bench for the GF(2^131) normal-basis ALU: directed edge cases
// then random items with random idle and stall gaps. Each result item is
// checked field by field against a behavioral field model or typed row values.
// ----------------------------------------------------------------------------
module gf2_131_onb_field_alu_test;

    localparam int unsigned N_RANDOM  = 1880;
    localparam int unsigned CYC_LIMIT = 6000000;
    localparam logic [2:0]  OP_RSVD6  = 3'd6;
    localparam logic [2:0]  OP_RSVD7  = 3'd7;

    typedef struct {
        logic [2:0]       op;
        gfonb_pkg::t_elem a;
        gfonb_pkg::t_elem b;
        logic [7:0]       j;
        bit               typed;
        gfonb_pkg::t_elem r;
        logic             ok;
    } t_row;

    typedef struct {
        gfonb_pkg::t_elem r;
        logic             ok;
        logic             tr;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [2:0]  i_opcode = '0;
    logic [63:0] i_a_word0 = '0, i_a_word1 = '0, i_b_word0 = '0, i_b_word1 = '0;
    logic [2:0]  i_a_word2 = '0, i_b_word2 = '0;
    logic [7:0]  i_frob_power = '0;
    logic        o_stall, o_valid, o_ok, o_trace_bit;
    logic [63:0] o_r_word0, o_r_word1;
    logic [2:0]  o_r_word2;

    t_result     pending_results[$];
    int unsigned n_errors = 0;
    int unsigned n_checked = 0;
    int unsigned n_inverse = 0;
    int unsigned cycle_cnt = 0;
    int unsigned stall_left = 0;
    bit          stim_done = 1'b0;

    gf2_131_onb_field_alu dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode,
        .i_a_word0, .i_a_word1, .i_a_word2, .i_b_word0, .i_b_word1, .i_b_word2,
        .i_frob_power, .o_valid, .i_stall,
        .o_r_word0, .o_r_word1, .o_r_word2, .o_ok, .o_trace_bit
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Fold an expansion index onto a basis index 1..131 (0 for entry 0).
    function automatic int unsigned basis_fold(input int unsigned k);
        k = k % gfonb_pkg::SymLen;
        return (k > gfonb_pkg::FieldDeg) ? gfonb_pkg::SymLen - k : k;
    endfunction

    // Basis permutation beta_i -> beta_fold(m*i).
    function automatic gfonb_pkg::t_elem permute_basis(input gfonb_pkg::t_elem x,
                                                       input int unsigned m);
        gfonb_pkg::t_elem r;
        r = '0;
        for (int unsigned i = 1; i <= gfonb_pkg::FieldDeg; i++)
            if (x[i-1]) r[basis_fold(m * i) - 1] = 1'b1;
        return r;
    endfunction

    function automatic gfonb_pkg::t_elem frobenius(input gfonb_pkg::t_elem x,
                                                   input int unsigned j);
        int unsigned m;
        m = 1;
        for (int unsigned k = 0; k < j % gfonb_pkg::FieldDeg; k++)
            m = (2 * m) % gfonb_pkg::SymLen;
        return permute_basis(x, m);
    endfunction

    // Cyclic convolution of the symmetric expansions, read back at 1..131.
    function automatic gfonb_pkg::t_elem field_mul(input gfonb_pkg::t_elem a,
                                                   input gfonb_pkg::t_elem b);
        gfonb_pkg::t_elem r;
        logic             s [gfonb_pkg::SymLen];
        logic             acc;
        for (int unsigned k = 0; k < gfonb_pkg::SymLen; k++)
            s[k] = (basis_fold(k) == 0) ? 1'b0 : a[basis_fold(k) - 1];
        r = '0;
        for (int unsigned k = 1; k <= gfonb_pkg::FieldDeg; k++) begin
            acc = 1'b0;
            for (int unsigned j = 1; j <= gfonb_pkg::FieldDeg; j++)
                if (b[j-1]) acc ^= s[(k + j) % gfonb_pkg::SymLen] ^
                                   s[(k + gfonb_pkg::SymLen - j) % gfonb_pkg::SymLen];
            r[k-1] = acc;
        end
        return r;
    endfunction

    // Itoh-Tsujii inversion along 1,2,4,...,64,65,130, then one squaring.
    function automatic gfonb_pkg::t_elem field_inverse(input gfonb_pkg::t_elem a);
        int unsigned chain [9] = '{1, 2, 4, 8, 16, 32, 64, 65, 130};
        int unsigned step;
        gfonb_pkg::t_elem acc;
        acc = a;
        for (int unsigned i = 1; i < 9; i++) begin
            step = chain[i] - chain[i-1];
            acc = field_mul(frobenius(acc, step), (step == chain[i-1]) ? acc : a);
        end
        return permute_basis(acc, 2);
    endfunction

    function automatic gfonb_pkg::t_elem half_trace(input gfonb_pkg::t_elem c);
        gfonb_pkg::t_elem acc, term;
        acc = c;
        term = c;
        for (int unsigned i = 1; i <= (gfonb_pkg::FieldDeg - 1) / 2; i++) begin
            term = permute_basis(term, 4);
            acc ^= term;
        end
        return acc;
    endfunction

    function automatic t_result alu_result(input t_row row);
        t_result e;
        e.r = '0;
        e.ok = 1'b1;
        e.tr = ^row.a;
        case (row.op)
            gfonb_pkg::OP_ADD:  e.r = row.a ^ row.b;
            gfonb_pkg::OP_MUL:  e.r = field_mul(row.a, row.b);
            gfonb_pkg::OP_SQR:  e.r = permute_basis(row.a, 2);
            gfonb_pkg::OP_FROB: e.r = frobenius(row.a, row.j);
            gfonb_pkg::OP_INV:  if (row.a == '0) e.ok = 1'b0; else e.r = field_inverse(row.a);
            gfonb_pkg::OP_HTR:  e.r = half_trace(row.a);
            default: ;
        endcase
        return e;
    endfunction

    function automatic gfonb_pkg::t_elem rand_elem();
        gfonb_pkg::t_elem x;
        case ($urandom_range(0, 9))
            0:       x = '0;
            1:       x = '1;
            2:       x = gfonb_pkg::t_elem'(1) << $urandom_range(0, gfonb_pkg::FieldDeg - 1);
            default: x = gfonb_pkg::t_elem'({$urandom, $urandom, $urandom, $urandom, $urandom});
        endcase
        return x;
    endfunction

    // Present one item after a random gap and hold it until accepted.
    task automatic send_item(input t_row row, input bit add_gap);
        int unsigned gap;
        gap = add_gap ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18)) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= row.op;
        i_a_word0    <= row.a[63:0];
        i_a_word1    <= row.a[127:64];
        i_a_word2    <= row.a[130:128];
        i_b_word0    <= row.b[63:0];
        i_b_word1    <= row.b[127:64];
        i_b_word2    <= row.b[130:128];
        i_frob_power <= row.j;
        do @(posedge i_clk); while (o_stall);
        if (row.op == gfonb_pkg::OP_INV) n_inverse++;
        pending_results.push_back(alu_result(row));
        if (row.typed) begin
            pending_results[$].r  = row.r;
            pending_results[$].ok = row.ok;
        end
    endtask

    // Result side: random stalls and a field-by-field check of each item.
    always @(posedge i_clk) begin
        t_result          e;
        gfonb_pkg::t_elem got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_r_word2, o_r_word1, o_r_word0};
            if (pending_results.size() == 0) begin
                $display("%0t: result item with none expected: r=%h", $time, got);
                n_errors++;
            end else begin
                e = pending_results.pop_front();
                n_checked++;
                if (got !== e.r) begin
                    $display("%0t: r mismatch: expected %h actual %h", $time, e.r, got);
                    n_errors++;
                end
                if (o_ok !== e.ok) begin
                    $display("%0t: ok mismatch: expected %b actual %b", $time, e.ok, o_ok);
                    n_errors++;
                end
                if (o_trace_bit !== e.tr) begin
                    $display("%0t: trace mismatch: expected %b actual %b",
                             $time, e.tr, o_trace_bit);
                    n_errors++;
                end
            end
            stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
            i_stall <= (stall_left != 0);
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= (stall_left != 0);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYC_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus: directed list, then random items, then drain.
    initial begin
        t_row             rows[$];
        t_row             row;
        gfonb_pkg::t_elem x;
        int unsigned      pick;
        x = gfonb_pkg::t_elem'({$urandom, $urandom, $urandom, $urandom, $urandom});
        rows.push_back('{gfonb_pkg::OP_ADD,  '0, '0, 8'd0, 1, '0, 1'b1});
        rows.push_back('{gfonb_pkg::OP_ADD,  '1, '0, 8'd0, 1, '1, 1'b1});
        rows.push_back('{gfonb_pkg::OP_ADD,  '1, '1, 8'd255, 1, '0, 1'b1});
        rows.push_back('{gfonb_pkg::OP_MUL,  '1, '1, 8'd0, 0, '0, 1'b1});
        rows.push_back('{gfonb_pkg::OP_MUL,  x, '1, 8'd0, 0, '0, 1'b1});
        rows.push_back('{gfonb_pkg::OP_MUL,  x, '0, 8'd0, 1, '0, 1'b1});
        rows.push_back('{gfonb_pkg::OP_SQR,  '1, '0, 8'd0, 1, '1, 1'b1});
        rows.push_back('{gfonb_pkg::OP_SQR,  x, '1, 8'd7, 0, '0, 1'b1});
        rows.push_back('{gfonb_pkg::OP_FROB, x, '0, 8'd0, 1, x, 1'b1});
        rows.push_back('{gfonb_pkg::OP_FROB, x, '0, 8'd131, 1, x, 1'b1});
        rows.push_back('{gfonb_pkg::OP_FROB, x, '0, 8'd130, 0, '0, 1'b1});
        rows.push_back('{gfonb_pkg::OP_FROB, x, '1, 8'd255, 0, '0, 1'b1});
        rows.push_back('{gfonb_pkg::OP_INV,  '0, '1, 8'd0, 1, '0, 1'b0});
        rows.push_back('{gfonb_pkg::OP_INV,  '1, '0, 8'd0, 0, '0, 1'b1});
        rows.push_back('{gfonb_pkg::OP_INV,  x, '0, 8'd0, 0, '0, 1'b1});
        rows.push_back('{gfonb_pkg::OP_HTR,  '0, '0, 8'd0, 1, '0, 1'b1});
        rows.push_back('{gfonb_pkg::OP_HTR,  x, '0, 8'd0, 0, '0, 1'b1});
        rows.push_back('{gfonb_pkg::OP_HTR,  '1, '0, 8'd0, 0, '0, 1'b1});
        rows.push_back('{OP_RSVD6, x, '1, 8'd0, 1, '0, 1'b1});
        rows.push_back('{OP_RSVD7, '1, '1, 8'd255, 1, '0, 1'b1});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_item(rows[k], 1'b1);

        for (int unsigned n = 0; n < N_RANDOM; n++) begin
            // Once midway, hold off until the unit has fully drained.
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            row.op = (pick < 18) ? gfonb_pkg::OP_ADD :
                     (pick < 40) ? gfonb_pkg::OP_MUL :
                     (pick < 55) ? gfonb_pkg::OP_SQR :
                     (pick < 75) ? gfonb_pkg::OP_FROB :
                     (pick < 85) ? gfonb_pkg::OP_INV :
                     (pick < 95) ? gfonb_pkg::OP_HTR :
                     3'($urandom_range(6, 7));
            row.a = rand_elem();
            row.b = rand_elem();
            row.j = 8'($urandom_range(0, 255));
            row.typed = 1'b0;
            row.r = '0;
            row.ok = 1'b1;
            send_item(row, (n % 200) >= 20);
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Checked %0d result items (%0d inversions), directed edge cases plus",
                 n_checked, n_inverse);
        $display("random operands, exponents and idle/stall gaps on both channels.");
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
